/* src/irp_pkg.sv */
// Package for the isotonic regression block: transaction structs and divider handshake.
// No dependencies.
`default_nettype none
package irp_pkg;
    localparam int unsigned SLOTS = 64;

    typedef struct packed {
        logic signed [31:0] sample_value;
        logic [15:0]        sample_weight;
        logic [5:0]         order_slot;
        logic               last_of_set;
    } sample_t;

    typedef struct packed {
        logic signed [31:0] fitted_value;
        logic [5:0]         element_index;
        logic               final_result;
    } result_t;

    typedef struct packed {
        logic               go;
        logic signed [53:0] num;
        logic [21:0]        den;
    } div_req_t;

    typedef struct packed {
        logic               done;
        logic signed [31:0] quo;
    } div_rsp_t;
endpackage
`default_nettype wire

/* src/isotonic_regression_pava.sv */
// Top level: element stores, pass sequencer and result emission for weighted isotonic regression.
// Depends on irp_pkg and irp_divider.
// A transaction that does not close a set is simply stored. Closing a set over m positions first gathers
// the occupied positions in order, then runs up to m passes that scan for a decrease, accumulate each
// block, divide it on the shared serial divider (skipped when the block weight is zero) and write the
// block mean back; then one result is emitted per loaded element.
// busy holds until the last result shows; the receiver cannot stall. Reset clears control state.
`default_nettype none
module isotonic_regression_pava (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire irp_pkg::sample_t  sample,
    output logic                   result_valid,
    output irp_pkg::result_t       result
);
    import irp_pkg::*;

    typedef enum logic [16:0] {
        S_LOAD   = 17'b00000000000000001,
        S_GATHER = 17'b00000000000000010,
        S_GVAL   = 17'b00000000000000100,
        S_GPUT   = 17'b00000000000001000,
        S_CREAD  = 17'b00000000000010000,
        S_CHECK  = 17'b00000000000100000,
        S_MUL    = 17'b00000000001000000,
        S_MWT    = 17'b00000000010000000,
        S_MPROD  = 17'b00000000100000000,
        S_ACC    = 17'b00000001000000000,
        S_DIV    = 17'b00000010000000000,
        S_WAIT   = 17'b00000100000000000,
        S_WRITE  = 17'b00001000000000000,
        S_EMIT   = 17'b00010000000000000,
        S_ESLOT  = 17'b00100000000000000,
        S_ERANK  = 17'b01000000000000000,
        S_EOUT   = 17'b10000000000000000
    } state_t;

    logic signed [31:0] value_mem [SLOTS];
    logic [15:0]        weight_mem [SLOTS];
    logic [5:0]         eslot_mem [SLOTS];
    logic [5:0]         smap_mem [SLOTS];
    logic [5:0]         seq_mem [SLOTS];
    logic [5:0]         rank_mem [SLOTS];
    logic signed [31:0] cur_mem [SLOTS];

    state_t             state_reg, state_next;
    logic [63:0]        valid_reg, valid_next;
    logic [6:0]         count_reg, count_next;
    logic [6:0]         m_reg, m_next;
    logic [6:0]         idx_reg, idx_next;
    logic [6:0]         rs_reg, rs_next;
    logic [5:0]         j_reg, j_next;
    logic [6:0]         passes_reg, passes_next;
    logic signed [31:0] prev_reg, prev_next;
    logic signed [31:0] first_reg, first_next;
    logic signed [48:0] prod_reg, prod_next;
    logic [15:0]        w_reg, w_next;
    logic signed [53:0] sum_reg, sum_next;
    logic [21:0]        tot_reg, tot_next;
    logic signed [31:0] mean_reg, mean_next;
    logic               rv_reg, rv_next;
    result_t            res_reg, res_next;

    logic [5:0]         load_k;
    logic               load_take;
    logic               cur_we;
    logic [5:0]         cur_addr;
    logic signed [31:0] cur_data;
    logic               rank_we;
    logic [5:0]         value_ra;
    logic [5:0]         smap_ra;
    logic [5:0]         cur_ra;
    logic signed [31:0] value_q;
    logic [15:0]        weight_q;
    logic [5:0]         eslot_q;
    logic [5:0]         smap_q;
    logic [5:0]         seq_q;
    logic [5:0]         rank_q;
    logic signed [31:0] cur_q;
    div_req_t           dreq;
    div_rsp_t           drsp;

    irp_divider u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (dreq),
        .rsp   (drsp)
    );

    assign busy      = (state_reg != S_LOAD);
    assign load_take = start && !busy;
    assign load_k    = count_reg[6] ? 6'd63 : count_reg[5:0];
    assign value_ra  = (state_reg == S_GVAL) ? smap_q : idx_reg[5:0];
    assign smap_ra   = (state_reg == S_ESLOT || state_reg == S_ERANK) ? eslot_q : idx_reg[5:0];
    assign cur_ra    = (state_reg == S_ERANK) ? rank_q : idx_reg[5:0];

    always_comb
    begin
        state_next  = state_reg;
        valid_next  = valid_reg;
        count_next  = count_reg;
        m_next      = m_reg;
        idx_next    = idx_reg;
        rs_next     = rs_reg;
        j_next      = j_reg;
        passes_next = passes_reg;
        prev_next   = prev_reg;
        first_next  = first_reg;
        prod_next   = prod_reg;
        w_next      = w_reg;
        sum_next    = sum_reg;
        tot_next    = tot_reg;
        mean_next   = mean_reg;
        rv_next     = 1'b0;
        res_next    = res_reg;
        cur_we      = 1'b0;
        cur_addr    = idx_reg[5:0];
        cur_data    = mean_reg;
        rank_we     = 1'b0;
        dreq.go     = 1'b0;
        dreq.num    = sum_reg;
        dreq.den    = tot_reg;
        unique case (state_reg)
            S_LOAD:
            begin
                if (load_take)
                begin
                    valid_next[sample.order_slot] = 1'b1;
                    count_next = {1'b0, load_k} + 7'd1;
                    if (sample.last_of_set || load_k == 6'd63)
                    begin
                        state_next = S_GATHER;
                        idx_next   = 7'd0;
                        m_next     = 7'd0;
                    end
                end
            end
            S_GATHER:
            begin
                if (valid_reg[idx_reg[5:0]])
                    state_next = S_GVAL;
                else
                begin
                    idx_next = idx_reg + 7'd1;
                    if (idx_reg[5:0] == 6'd63)
                    begin
                        idx_next    = 7'd0;
                        passes_next = 7'd0;
                        state_next  = (m_reg > 7'd1) ? S_CREAD : S_EMIT;
                    end
                end
            end
            S_GVAL:
            begin
                state_next = S_GPUT;
            end
            S_GPUT:
            begin
                cur_we     = 1'b1;
                cur_addr   = m_reg[5:0];
                cur_data   = value_q;
                rank_we    = 1'b1;
                m_next     = m_reg + 7'd1;
                idx_next   = idx_reg + 7'd1;
                state_next = S_GATHER;
                if (idx_reg[5:0] == 6'd63)
                begin
                    idx_next    = 7'd0;
                    passes_next = 7'd0;
                    state_next  = (m_next > 7'd1) ? S_CREAD : S_EMIT;
                end
            end
            S_CREAD:
            begin
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                if (passes_reg == m_reg)
                begin
                    idx_next   = 7'd0;
                    state_next = S_EMIT;
                end
                else if (idx_reg != 7'd0 && cur_q < prev_reg)
                begin
                    idx_next   = 7'd0;
                    rs_next    = 7'd0;
                    sum_next   = 54'sd0;
                    tot_next   = 22'd0;
                    state_next = S_MUL;
                end
                else
                begin
                    prev_next  = cur_q;
                    idx_next   = idx_reg + 7'd1;
                    state_next = S_CREAD;
                    if (idx_reg == m_reg - 7'd1)
                    begin
                        idx_next   = 7'd0;
                        state_next = S_EMIT;
                    end
                end
            end
            S_MUL:
            begin
                state_next = S_MWT;
            end
            S_MWT:
            begin
                if (idx_reg != rs_reg && cur_q > prev_reg)
                    state_next = S_DIV;
                else
                begin
                    if (idx_reg == rs_reg)
                        first_next = cur_q;
                    prev_next  = cur_q;
                    state_next = S_MPROD;
                end
            end
            S_MPROD:
            begin
                w_next     = weight_q;
                prod_next  = 49'(cur_q * $signed({1'b0, weight_q}));
                state_next = S_ACC;
            end
            S_ACC:
            begin
                sum_next = sum_reg + 54'(prod_reg);
                tot_next = tot_reg + 22'(w_reg);
                idx_next = idx_reg + 7'd1;
                state_next = (idx_next == m_reg) ? S_DIV : S_MUL;
            end
            S_DIV:
            begin
                j_next = rs_reg[5:0];
                if (tot_reg == 22'd0)
                begin
                    mean_next  = first_reg;
                    state_next = S_WRITE;
                end
                else
                begin
                    dreq.go    = 1'b1;
                    state_next = S_WAIT;
                end
            end
            S_WAIT:
            begin
                if (drsp.done)
                begin
                    mean_next  = drsp.quo;
                    state_next = S_WRITE;
                end
            end
            S_WRITE:
            begin
                cur_we   = 1'b1;
                cur_addr = j_reg;
                cur_data = mean_reg;
                j_next   = j_reg + 6'd1;
                if ({1'b0, j_reg} == idx_reg - 7'd1)
                begin
                    if (idx_reg == m_reg)
                    begin
                        passes_next = passes_reg + 7'd1;
                        idx_next    = 7'd0;
                        state_next  = S_CREAD;
                    end
                    else
                    begin
                        rs_next    = idx_reg;
                        sum_next   = 54'sd0;
                        tot_next   = 22'd0;
                        state_next = S_MUL;
                    end
                end
            end
            S_EMIT:
            begin
                state_next = S_ESLOT;
            end
            S_ESLOT:
            begin
                state_next = S_ERANK;
            end
            S_ERANK:
            begin
                state_next = S_EOUT;
            end
            S_EOUT:
            begin
                rv_next = 1'b1;
                res_next.element_index = idx_reg[5:0];
                res_next.final_result  = (idx_reg == count_reg - 7'd1);
                if (valid_reg[eslot_q] && smap_q == idx_reg[5:0])
                    res_next.fitted_value = cur_q;
                else
                    res_next.fitted_value = value_q;
                idx_next   = idx_reg + 7'd1;
                state_next = S_EMIT;
                if (idx_reg == count_reg - 7'd1)
                begin
                    count_next = 7'd0;
                    valid_next = 64'd0;
                    state_next = S_LOAD;
                end
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_LOAD;
            valid_reg  <= 64'd0;
            count_reg  <= 7'd0;
            m_reg      <= 7'd0;
            idx_reg    <= 7'd0;
            rs_reg     <= 7'd0;
            j_reg      <= 6'd0;
            passes_reg <= 7'd0;
            rv_reg     <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            valid_reg  <= valid_next;
            count_reg  <= count_next;
            m_reg      <= m_next;
            idx_reg    <= idx_next;
            rs_reg     <= rs_next;
            j_reg      <= j_next;
            passes_reg <= passes_next;
            rv_reg     <= rv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prev_reg  <= prev_next;
        first_reg <= first_next;
        prod_reg  <= prod_next;
        w_reg     <= w_next;
        sum_reg   <= sum_next;
        tot_reg   <= tot_next;
        mean_reg  <= mean_next;
        res_reg   <= res_next;
    end

    always_ff @(posedge clk)
    begin
        if (load_take)
        begin
            value_mem[load_k]            <= sample.sample_value;
            weight_mem[load_k]           <= sample.sample_weight;
            eslot_mem[load_k]            <= sample.order_slot;
            smap_mem[sample.order_slot]  <= load_k;
        end
        if (cur_we)
            cur_mem[cur_addr] <= cur_data;
        if (rank_we)
        begin
            seq_mem[m_reg[5:0]]    <= smap_q;
            rank_mem[idx_reg[5:0]] <= m_reg[5:0];
        end
        value_q  <= value_mem[value_ra];
        weight_q <= weight_mem[seq_q];
        eslot_q  <= eslot_mem[idx_reg[5:0]];
        smap_q   <= smap_mem[smap_ra];
        seq_q    <= seq_mem[idx_reg[5:0]];
        rank_q   <= rank_mem[eslot_q];
        cur_q    <= cur_mem[cur_ra];
    end

    assign result_valid = rv_reg;
    assign result       = res_reg;

    a_result_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
        rv_reg |-> $past(state_reg == S_EOUT)) else $error("result outside emission");
    a_div_to_write: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WAIT && drsp.done) |=> state_reg == S_WRITE)
        else $error("divide result dropped");
    a_full_set_closes: assert property (@(posedge clk) disable iff (!rst_n)
        (load_take && count_reg == 7'd63) |=> busy) else $error("full store not closed");
    a_final_ends_set: assert property (@(posedge clk) disable iff (!rst_n)
        (rv_reg && res_reg.final_result) |-> count_reg == 7'd0)
        else $error("final result before set closed");
endmodule
`default_nettype wire

/* src/irp_divider.sv */
// Bit-serial signed-by-unsigned divider, truncating toward zero, one quotient bit per cycle.
// Depends on irp_pkg.
`default_nettype none
module irp_divider (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire irp_pkg::div_req_t req,
    output irp_pkg::div_rsp_t    rsp
);
    import irp_pkg::*;

    logic        run_reg, run_next;
    logic        done_reg, done_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic [53:0] quo_reg, quo_next;
    logic [22:0] rem_reg, rem_next;
    logic [21:0] den_reg, den_next;
    logic        neg_reg, neg_next;
    logic [22:0] shifted;
    logic [53:0] quo_mag;

    assign shifted = {rem_reg[21:0], quo_reg[53]};
    assign quo_mag = neg_reg ? (~quo_reg + 54'd1) : quo_reg;

    always_comb
    begin
        run_next  = run_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        neg_next  = neg_reg;
        if (req.go)
        begin
            run_next = 1'b1;
            cnt_next = 6'd0;
            neg_next = req.num[53];
            quo_next = req.num[53] ? (~req.num + 54'd1) : req.num;
            rem_next = 23'd0;
            den_next = req.den;
        end
        else if (run_reg)
        begin
            if (shifted >= {1'b0, den_reg})
            begin
                rem_next = shifted - {1'b0, den_reg};
                quo_next = {quo_reg[52:0], 1'b1};
            end
            else
            begin
                rem_next = shifted;
                quo_next = {quo_reg[52:0], 1'b0};
            end
            cnt_next = cnt_reg + 6'd1;
            if (cnt_reg == 6'd53)
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 6'd0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
        neg_reg <= neg_next;
    end

    assign rsp = {done_reg, quo_mag[31:0]};

    a_done_after_run: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(run_reg)) else $error("divider done without run");
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !run_reg) else $error("divider still running at done");
    a_count_end: assert property (@(posedge clk) disable iff (!rst_n)
        (run_reg && !req.go && cnt_reg == 6'd53) |=> done_reg)
        else $error("divider missed its last step");
endmodule
`default_nettype wire

/* tb/isotonic_regression_pava_test.sv */
// Testbench for isotonic_regression_pava: loads data sets, predicts the pooled
// fits and checks every result. Depends on irp_pkg and the isotonic_regression_pava RTL.
`default_nettype none
module isotonic_regression_pava_test;
    timeunit 1ns;
    timeprecision 1ps;
    import irp_pkg::*;

    class fit_scoreboard;
        logic signed [31:0] value_mem[64];
        logic [15:0]        weight_mem[64];
        logic [5:0]         elem_slot[64];
        logic [5:0]         slot_owner[64];
        bit                 slot_used[64];
        int                 loaded;
        int                 fit_val[64];
        int                 order_elem[64];
        int                 rank_of[64];
        int                 label[64];
        longint             block_sum[64];
        longint             block_wt[64];
        int                 block_first[64];
        result_t            pending[$];
        int                 errors;
        int                 checked;
        int                 sets;

        function new();
            loaded = 0;
            errors = 0;
            checked = 0;
            sets = 0;
            foreach (slot_used[i]) slot_used[i] = 0;
        endfunction

        function bit decreasing(int m);
            for (int i = 1; i < m; i++)
                if (fit_val[i] < fit_val[i-1]) return 1;
            return 0;
        endfunction

        function void pool_pass(int m);
            int b;
            int nb;
            label[0] = 0;
            for (int i = 1; i < m; i++)
                label[i] = label[i-1] + ((fit_val[i] > fit_val[i-1]) ? 1 : 0);
            nb = label[m-1] + 1;
            for (int i = 0; i < nb; i++)
            begin
                block_sum[i] = 0;
                block_wt[i] = 0;
            end
            for (int i = 0; i < m; i++)
            begin
                b = label[i];
                if (i == 0 || label[i-1] != b) block_first[b] = fit_val[i];
                block_sum[b] += longint'(fit_val[i]) * longint'(weight_mem[order_elem[i]]);
                block_wt[b] += longint'(weight_mem[order_elem[i]]);
            end
            for (int i = 0; i < m; i++)
            begin
                b = label[i];
                if (block_wt[b] == 0) fit_val[i] = block_first[b];
                else fit_val[i] = int'(block_sum[b] / block_wt[b]);
            end
        endfunction

        function void fit_set();
            int m;
            int passes;
            int s;
            result_t r;
            m = 0;
            passes = 0;
            for (int p = 0; p < 64; p++)
            begin
                rank_of[p] = 0;
                if (slot_used[p])
                begin
                    order_elem[m] = slot_owner[p];
                    fit_val[m] = value_mem[slot_owner[p]];
                    rank_of[p] = m;
                    m++;
                end
            end
            while (m > 1 && passes < m && decreasing(m))
            begin
                pool_pass(m);
                passes++;
            end
            for (int k = 0; k < loaded; k++)
            begin
                s = elem_slot[k];
                r.fitted_value = value_mem[k];
                if (slot_owner[s] == k) r.fitted_value = fit_val[rank_of[s]];
                r.element_index = k[5:0];
                r.final_result = (k + 1 == loaded);
                pending.push_back(r);
            end
            loaded = 0;
            foreach (slot_used[i]) slot_used[i] = 0;
            sets++;
        endfunction

        function void note_sample(sample_t t);
            int k;
            k = (loaded >= 64) ? 63 : loaded;
            value_mem[k] = t.sample_value;
            weight_mem[k] = t.sample_weight;
            elem_slot[k] = t.order_slot;
            slot_owner[t.order_slot] = k[5:0];
            slot_used[t.order_slot] = 1;
            loaded = k + 1;
            if (t.last_of_set || loaded >= 64) fit_set();
        endfunction

        function void check_result(result_t got);
            result_t want;
            if (pending.size() == 0)
            begin
                $error("unexpected result: fitted_value %0d element_index %0d",
                       got.fitted_value, got.element_index);
                errors++;
                return;
            end
            want = pending.pop_front();
            checked++;
            if (got.fitted_value !== want.fitted_value)
            begin
                $error("fitted_value: expected %0d, actual %0d", want.fitted_value,
                       got.fitted_value);
                errors++;
            end
            if (got.element_index !== want.element_index)
            begin
                $error("element_index: expected %0d, actual %0d", want.element_index,
                       got.element_index);
                errors++;
            end
            if (got.final_result !== want.final_result)
            begin
                $error("final_result: expected %0d, actual %0d", want.final_result,
                       got.final_result);
                errors++;
            end
        endfunction
    endclass

    logic    clk;
    logic    rst_n;
    logic    start;
    logic    busy;
    sample_t sample;
    logic    result_valid;
    result_t result;

    fit_scoreboard sb;
    bit      no_gaps;
    int      sent;
    int      slot_pool[64];

    isotonic_regression_pava dut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .sample(sample),
        .result_valid(result_valid),
        .result(result)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    always @(posedge clk)
    begin
        if (rst_n && result_valid) sb.check_result(result);
    end

    task automatic send_sample(logic signed [31:0] v, logic [15:0] w, logic [5:0] s,
                               logic last);
        int gap;
        sample_t t;
        gap = no_gaps ? 0 : $urandom_range(0, 11);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        t.sample_value = v;
        t.sample_weight = w;
        t.order_slot = s;
        t.last_of_set = last;
        start <= 1'b1;
        sample <= t;
        do @(posedge clk); while (busy);
        sb.note_sample(t);
        sent++;
    endtask

    task automatic drain();
        start <= 1'b0;
        while (sb.pending.size() != 0) @(posedge clk);
    endtask

    task automatic shuffle_slots();
        int j;
        int tmp;
        for (int i = 0; i < 64; i++) slot_pool[i] = i;
        for (int i = 63; i > 0; i--)
        begin
            j = $urandom_range(0, i);
            tmp = slot_pool[i];
            slot_pool[i] = slot_pool[j];
            slot_pool[j] = tmp;
        end
    endtask

    function automatic logic signed [31:0] draw_value(int mode);
        if (mode == 0) return $urandom;
        return ($signed($urandom_range(0, 2000)) - 1000) * 65536 + $urandom_range(0, 65535);
    endfunction

    task automatic random_set(int n, bit dup_slots, bit close_it);
        int mode;
        shuffle_slots();
        mode = $urandom_range(0, 3);
        for (int i = 0; i < n; i++)
            send_sample(draw_value(mode), 16'($urandom_range(1, 65535)),
                        dup_slots ? 6'($urandom_range(0, 63)) : 6'(slot_pool[i]),
                        close_it && (i == n - 1));
    endtask

    initial
    begin
        #20ms;
        $display("FAILURE");
        $finish;
    end

    initial
    begin
        sb = new();
        rst_n = 1'b0;
        start = 1'b0;
        sample = '0;
        no_gaps = 0;
        sent = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_sample(32'sh7FFFFFFF, 16'hFFFF, 6'd63, 1'b1);
        send_sample(-32'sd5, 16'h0100, 6'd0, 1'b0);
        send_sample(32'sd0, 16'h0001, 6'd1, 1'b0);
        send_sample(32'sd7, 16'h0200, 6'd2, 1'b1);
        send_sample(32'sh7FFFFFFF, 16'hFFFF, 6'd3, 1'b0);
        send_sample(32'sh80000000, 16'hFFFF, 6'd9, 1'b0);
        send_sample(32'sh12345678, 16'h0001, 6'd0, 1'b1);
        send_sample(32'sd900, 16'h0100, 6'd40, 1'b0);
        send_sample(32'sd100, 16'h0300, 6'd5, 1'b0);
        send_sample(-32'sd300, 16'h0080, 6'd63, 1'b1);
        send_sample(32'sd50, 16'h0100, 6'd4, 1'b0);
        send_sample(32'sd10, 16'h0100, 6'd4, 1'b0);
        send_sample(32'sd20, 16'h0100, 6'd8, 1'b0);
        send_sample(32'sd5, 16'h0100, 6'd6, 1'b1);
        send_sample(32'sd400, 16'h0000, 6'd1, 1'b0);
        send_sample(32'sd200, 16'h0000, 6'd2, 1'b0);
        send_sample(32'sd300, 16'h0002, 6'd3, 1'b1);
        drain();

        no_gaps = 1;
        random_set(64, 0, 0);
        no_gaps = 0;
        while (sent < 100)
        begin
            no_gaps = ($urandom_range(0, 4) == 0);
            random_set(($urandom_range(0, 7) == 0) ? 1 : $urandom_range(2, 8),
                       $urandom_range(0, 5) == 0, 1);
            if ($urandom_range(0, 6) == 0) drain();
        end
        drain();
        repeat (100) @(posedge clk);

        $display("Loaded %0d samples in %0d sets; %0d fitted values checked.",
                 sent, sb.sets, sb.checked);
        $display("Covered value and weight extremes, gaps, shared slots and a full store.");
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule
`default_nettype wire

/* isotonic_regression_pava.f */
src/irp_pkg.sv
src/irp_divider.sv
src/isotonic_regression_pava.sv
tb/isotonic_regression_pava_test.sv
